// ----- rtl/ksa_pkg.sv -----
`default_nettype none
package ksa_pkg;

  localparam int SLOTS    = 16;
  localparam int KEY_BITS = 32;
  localparam int IDX_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W    = $clog2(SLOTS + 1);
  localparam int SLOT_W   = 5;
  localparam int CMD_W    = 2;

  localparam logic [CMD_W-1:0] CMD_ALLOCATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RESERVE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE  = 2'd2;

  typedef enum logic [1:0] {
    ST_VACANT   = 2'd0,
    ST_RESERVED = 2'd1,
    ST_OCCUPIED = 2'd2
  } slot_state_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  typedef struct packed {
    logic [CMD_W-1:0]    command;
    logic [KEY_BITS-1:0] key;
    logic [SLOT_W-1:0]   requested_slot;
  } in_word_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic              ok;
    logic [SLOT_W-1:0] used_count;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

  // lowest set bit
  function automatic logic [IDX_W-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/ksa_ctrl.sv -----
`default_nettype none
module ksa_ctrl
  import ksa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic out_stall,
  output logic      in_stall,
  output logic      out_valid,
  output ctrl_cmd_t cmd
);

  ctrl_state_t state, state_next;
  logic        out_valid_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!out_valid || !out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state != S_IDLE);
    cmd.load = (state == S_IDLE) && in_valid;
    cmd.exec = (state == S_EXEC) && (!out_valid || !out_stall);
    out_valid_next = out_valid;
    if (cmd.exec) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ksa_datapath.sv -----
`default_nettype none
module ksa_datapath
  import ksa_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire ctrl_cmd_t   cmd,
  input  wire in_word_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic [SLOT_W-1:0] cfg_data,
  output out_word_t        out_data
);

  in_word_t             cur;
  logic [SLOT_W-1:0]    slots_in_use;
  slot_state_t          status [SLOTS];
  logic [KEY_BITS-1:0]  keys   [SLOTS];
  logic [CNT_W-1:0]     used_total, used_next;

  logic [CNT_W-1:0]     cap;
  logic [SLOTS-1:0]     res_hit, vac, rel_hit;
  logic [IDX_W-1:0]     req_idx;
  logic                 req_vac;

  logic                 wr_en, wr_key;
  logic [IDX_W-1:0]     wr_idx;
  slot_state_t          wr_state;
  logic                 inc, dec;
  out_word_t            res_next;

  assign cap     = (slots_in_use > SLOT_W'(SLOTS)) ? CNT_W'(SLOTS) : CNT_W'(slots_in_use);
  assign req_idx = IDX_W'(cur.requested_slot - SLOT_W'(1));
  assign req_vac = (cur.requested_slot != '0) && (cur.requested_slot <= cap) &&
                   (status[req_idx] == ST_VACANT);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      res_hit[i] = (i < cap) && (status[i] == ST_RESERVED) && (keys[i] == cur.key);
      vac[i]     = (i < cap) && (status[i] == ST_VACANT);
      rel_hit[i] = (i < cap) && (status[i] != ST_VACANT) && (keys[i] == cur.key);
    end
  end

  always_comb begin
    wr_en    = 1'b0;
    wr_key   = 1'b0;
    wr_idx   = '0;
    wr_state = ST_OCCUPIED;
    inc      = 1'b0;
    dec      = 1'b0;
    case (cur.command)
      CMD_ALLOCATE: begin
        if (req_vac) begin
          wr_en  = 1'b1;
          wr_key = 1'b1;
          wr_idx = req_idx;
          inc    = 1'b1;
        end else if (|res_hit) begin
          wr_en  = 1'b1;
          wr_idx = first_set(res_hit);
        end else if ((used_total < cap) && (|vac)) begin
          wr_en  = 1'b1;
          wr_key = 1'b1;
          wr_idx = first_set(vac);
          inc    = 1'b1;
        end
      end
      CMD_RESERVE: begin
        if (req_vac) begin
          wr_en    = 1'b1;
          wr_key   = 1'b1;
          wr_idx   = req_idx;
          wr_state = ST_RESERVED;
          inc      = 1'b1;
        end
      end
      CMD_RELEASE: begin
        if (|rel_hit) begin
          wr_en    = 1'b1;
          wr_idx   = first_set(rel_hit);
          wr_state = ST_VACANT;
          dec      = 1'b1;
        end
      end
      default: ;
    endcase

    used_next = used_total;
    if (inc && (used_total < CNT_W'(SLOTS))) used_next = used_total + CNT_W'(1);
    if (dec && (used_total != '0))           used_next = used_total - CNT_W'(1);

    res_next.ok         = wr_en;
    res_next.slot       = wr_en ? (SLOT_W'(wr_idx) + SLOT_W'(1)) : '0;
    res_next.used_count = SLOT_W'(used_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slots_in_use <= SLOT_W'(SLOTS);
      used_total   <= '0;
      for (int i = 0; i < SLOTS; i++) status[i] <= ST_VACANT;
    end else begin
      if (cfg_we) slots_in_use <= cfg_data;
      if (cmd.exec) begin
        used_total <= used_next;
        if (wr_en) status[wr_idx] <= wr_state;
      end
    end
  end

  // keys of vacant slots are never compared, so they need no reset
  always_ff @(posedge clk) begin
    if (cmd.load) cur <= in_data;
    if (cmd.exec) begin
      out_data <= res_next;
      if (wr_en && wr_key) keys[wr_idx] <= cur.key;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/keyed_slot_allocator_with_reserve.sv -----
`default_nettype none
// Keyed slot allocator with reserve.
// Input channel in_valid/in_stall/in_data carries one command word: allocate,
// reserve or release, with a key and an optional requested slot (from 1).
// Output channel out_valid/out_stall/out_data returns one word per command:
// slot number (0 on failure), ok flag and the used-slot count afterwards.
// cfg_we/cfg_data writes slots_in_use; write it only while the block is idle.
// Timing: a word accepted in idle is loaded into the command register and is
// processed in the execute state, which waits while a held result is stalled;
// the result is registered into the output register. The block takes no new
// word until it returns to idle after execute, and the execute cycle holds the
// full-table key compare, priority encode and the table write-back.
// A result waiting in the output register does not block the next input
// word; a second result waits in execute until out_stall drops.
// Reset (rst, synchronous) marks every slot vacant, clears the used count,
// sets slots_in_use to 16 and empties the output register.
module keyed_slot_allocator_with_reserve
  import ksa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_word_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_word_t              out_data,
  input  wire logic              cfg_we,
  input  wire logic [SLOT_W-1:0] cfg_data
);

  ctrl_cmd_t cmd;

  ksa_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  ksa_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .out_data (out_data)
  );

  a_exec_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.exec |=> out_valid)
    else $error("result not presented after execute");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken during execute");

  a_ok_slot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.ok == (out_data.slot != '0)))
    else $error("ok flag disagrees with slot");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.used_count <= SLOT_W'(SLOTS)))
    else $error("used count above table depth");

endmodule
`default_nettype wire

// ----- tb/ksa_result_tracker.sv -----
module ksa_result_tracker
  import ksa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire in_word_t          in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire out_word_t         out_data,
  input  wire logic              cfg_we,
  input  wire logic [SLOT_W-1:0] cfg_data,
  output int                     mismatches,
  output int                     pending
);

  slot_state_t         status [SLOTS];
  logic [KEY_BITS-1:0] key_of [SLOTS];
  int                  used;
  logic [SLOT_W-1:0]   enabled_reg;
  out_word_t           expected_q [$];

  // applies one command word to the table copy, returns the result word
  function automatic out_word_t apply_command(input in_word_t w);
    out_word_t r;
    int cap;
    int req;
    int hit;
    int take;
    bit req_ok;
    cap = (enabled_reg > SLOTS) ? SLOTS : int'(enabled_reg);
    req = int'(w.requested_slot);
    hit = 0;
    take = 0;
    req_ok = 1'b0;
    if (req >= 1 && req <= cap) req_ok = (status[req-1] == ST_VACANT);
    case (w.command)
      CMD_ALLOCATE: begin
        if (req_ok) begin
          take = req;
        end else begin
          for (int i = cap - 1; i >= 0; i--)
            if (status[i] == ST_RESERVED && key_of[i] == w.key) hit = i + 1;
          if (hit != 0) begin
            status[hit-1] = ST_OCCUPIED;
          end else if (used < cap) begin
            for (int i = cap - 1; i >= 0; i--)
              if (status[i] == ST_VACANT) take = i + 1;
          end
        end
        if (take != 0) begin
          status[take-1] = ST_OCCUPIED;
          key_of[take-1] = w.key;
          if (used < SLOTS) used++;
          hit = take;
        end
      end
      CMD_RESERVE: begin
        if (req_ok) begin
          status[req-1] = ST_RESERVED;
          key_of[req-1] = w.key;
          if (used < SLOTS) used++;
          hit = req;
        end
      end
      CMD_RELEASE: begin
        for (int i = cap - 1; i >= 0; i--)
          if (status[i] != ST_VACANT && key_of[i] == w.key) hit = i + 1;
        if (hit != 0) begin
          status[hit-1] = ST_VACANT;
          key_of[hit-1] = '0;
          if (used > 0) used--;
        end
      end
      default: ;
    endcase
    r.slot = SLOT_W'(hit);
    r.ok = (hit != 0);
    r.used_count = SLOT_W'(used);
    return r;
  endfunction

  always @(posedge clk) begin : track
    out_word_t got;
    out_word_t want;
    if (rst) begin
      foreach (status[i]) begin
        status[i] = ST_VACANT;
        key_of[i] = '0;
      end
      used = 0;
      enabled_reg = SLOT_W'(SLOTS);
      expected_q.delete();
      mismatches = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word: slot=%0d ok=%0d used=%0d", $time,
                   got.slot, got.ok, got.used_count);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          if (got.slot !== want.slot || got.ok !== want.ok ||
              got.used_count !== want.used_count) begin
            $display("%0t: expected slot=%0d ok=%0d used=%0d, got slot=%0d ok=%0d used=%0d",
                     $time, want.slot, want.ok, want.used_count,
                     got.slot, got.ok, got.used_count);
            mismatches++;
          end
        end
      end
      if (cfg_we) enabled_reg = cfg_data;
      if (in_valid && !in_stall) expected_q.push_back(apply_command(in_data));
    end
    pending = expected_q.size();
  end

endmodule

// ----- tb/keyed_slot_allocator_with_reserve_tb.sv -----
module keyed_slot_allocator_with_reserve_tb;
  import ksa_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  in_word_t          in_data = '0;
  logic              out_stall = 1'b0;
  logic              cfg_we = 1'b0;
  logic [SLOT_W-1:0] cfg_data = '0;
  logic              in_stall;
  logic              out_valid;
  out_word_t         out_data;
  int                mismatches;
  int                pending;

  int idle_pct = 0;
  int stall_pct = 0;
  int cur_slots = SLOTS;
  logic [KEY_BITS-1:0] key_pool [8];

  always #6 clk = ~clk;

  keyed_slot_allocator_with_reserve dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  ksa_result_tracker u_tracker (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  function automatic in_word_t cmd_word(input logic [CMD_W-1:0] c,
                                        input logic [KEY_BITS-1:0] k,
                                        input int req);
    in_word_t w;
    w.command = c;
    w.key = k;
    w.requested_slot = SLOT_W'(req);
    return w;
  endfunction

  // biased toward slots that are currently enabled
  function automatic int pick_slot();
    if (cur_slots > 0 && $urandom_range(1) == 0) return $urandom_range(cur_slots, 1);
    return $urandom_range(SLOTS, 0);
  endfunction

  function automatic logic [KEY_BITS-1:0] pick_key();
    if ($urandom_range(9) == 0) return $urandom();
    return key_pool[$urandom_range(7)];
  endfunction

  task automatic send_word(input in_word_t w);
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_slots(input int v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= SLOT_W'(v);
    cur_slots = (v > SLOTS) ? SLOTS : v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int settings [8];
    int n;
    int pick;
    logic [KEY_BITS-1:0] k;
    logic [CMD_W-1:0] c;
    settings = '{1, 4, 0, 16, 31, 17, 9, 2};
    settings[6] = $urandom_range(15, 2);
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < 8; i++) key_pool[i] = $urandom();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    send_word(cmd_word(CMD_RELEASE, 32'd5, 0));
    send_word(cmd_word(CMD_ALLOCATE, 32'hFFFF_FFFF, 16));
    send_word(cmd_word(CMD_ALLOCATE, 32'h0, 0));
    send_word(cmd_word(CMD_RESERVE, 32'hA5A5_5A5A, 3));
    send_word(cmd_word(CMD_RESERVE, 32'd1, 3));
    send_word(cmd_word(CMD_RESERVE, 32'd1, 0));
    send_word(cmd_word(CMD_ALLOCATE, 32'hA5A5_5A5A, 16));
    send_word(cmd_word(CMD_ALLOCATE, 32'd7, 1));
    send_word(cmd_word(CMD_UNUSED, 32'hFFFF_FFFF, 16));
    send_word(cmd_word(CMD_RELEASE, 32'h0, 0));
    send_word(cmd_word(CMD_RELEASE, 32'hFFFF_FFFF, 0));
    send_word(cmd_word(CMD_RELEASE, 32'h1234_5678, 0));
    send_word(cmd_word(CMD_RESERVE, 32'h5555_AAAA, 16));
    send_word(cmd_word(CMD_ALLOCATE, 32'h5555_AAAA, 0));
    send_word(cmd_word(CMD_RELEASE, 32'hA5A5_5A5A, 0));
    send_word(cmd_word(CMD_RELEASE, 32'h0, 0));
    send_word(cmd_word(CMD_ALLOCATE, 32'd1, 1));
    send_word(cmd_word(CMD_ALLOCATE, 32'h0F0F_0F0F, 0));

    for (int phase = 0; phase < 8; phase++) begin
      set_slots(settings[phase]);
      case (phase % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 76; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 76; end
        default: begin idle_pct = 27; stall_pct = 27; end
      endcase
      n = 0;
      while (n < 160) begin
        pick = $urandom_range(99);
        if (pick < 15) begin
          // reserve, then allocate with the same key (claims it unless the requested slot is vacant)
          k = pick_key();
          send_word(cmd_word(CMD_RESERVE, k, pick_slot()));
          send_word(cmd_word(CMD_ALLOCATE, k, pick_slot()));
          n += 2;
        end else begin
          c = (pick < 50) ? CMD_ALLOCATE : (pick < 68) ? CMD_RESERVE :
              (pick < 96) ? CMD_RELEASE : CMD_UNUSED;
          send_word(cmd_word(c, pick_key(), pick_slot()));
          n++;
        end
      end
    end

    settle();
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(12 * 400_000);
    $display("Mismatches found");
    $finish;
  end

endmodule
